// ===== design/ism_pkg.sv =====
package ism_pkg;

    // Field widths fixed by the instruction and result formats
    localparam int unsigned DATA_W          = 32;
    localparam int unsigned OP_W            = 4;
    localparam int unsigned DEPTH_OUT_W     = 11;
    localparam int unsigned STACK_DEPTH_DEF = 1024;

    typedef enum logic [OP_W-1:0] {
        OP_CONST = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_MAX   = 4'd5,
        OP_MIN   = 4'd6,
        OP_NEG   = 4'd7,
        OP_DUP   = 4'd8,
        OP_SWAP  = 4'd9
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

endpackage

// ===== design/ism_req_if.sv =====
interface ism_req_if import ism_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          req_type;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);

endinterface

// ===== design/ism_rsp_if.sv =====
interface ism_rsp_if import ism_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] bottom_value;
    logic [DEPTH_OUT_W-1:0]   stack_depth_out;
    logic [1:0]               status;

    modport source (output valid, output top_value, output bottom_value,
                    output stack_depth_out, output status, input ready);
    modport sink   (input valid, input top_value, input bottom_value,
                    input stack_depth_out, input status, output ready);

endinterface

// ===== design/integer_stack_machine.sv =====
// Channel  Role    Payload                                            Beat
// req      sink    req_type, push_value                               one instruction
// rsp      source  top_value, bottom_value, stack_depth_out, status   one result
//
// One instruction at a time. CONST, DUP, NEG and unused opcodes go from decode
// to the response; ADD, SUB, MAX, MIN pass a read state; SWAP and MUL a read
// and a write-back state; DIV waits on the divider, which retires one quotient
// bit per cycle. The top entry is cached in a register, so each instruction needs
// at most one read of the stack memory. Reset clears the depth, top and bottom
// registers, not the memory. A stalled result is held in the output register
// while the next instruction is taken; the next result waits until it has gone.
module integer_stack_machine import ism_pkg::*; #(
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ism_req_if.sink      req,
    ism_rsp_if.source    rsp
);

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_DIV,
        S_WB,
        S_RESP
    } state_t;

    state_t                 state_reg,      state_next;
    opcode_t                op_reg,         op_next;
    logic [DATA_W-1:0]      val_reg,        val_next;
    logic [DW-1:0]          depth_reg,      depth_next;
    logic [DATA_W-1:0]      top_reg,        top_next;
    logic [DATA_W-1:0]      bottom_reg,     bottom_next;
    status_t                status_reg,     status_next;
    logic [DATA_W-1:0]      res_reg,        res_next;
    logic                   out_valid_reg,  out_valid_next;
    logic [DATA_W-1:0]      out_top_reg,    out_top_next;
    logic [DATA_W-1:0]      out_bottom_reg, out_bottom_next;
    logic [DW-1:0]          out_depth_reg,  out_depth_next;
    status_t                out_status_reg, out_status_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [DATA_W-1:0]      ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [DATA_W-1:0]      ram_rdata;

    logic                   div_start;
    logic                   div_done;
    logic [DATA_W-1:0]      div_quot;

    logic [DATA_W-1:0]      alu_a;
    logic [DATA_W-1:0]      alu_b;
    logic [DATA_W-1:0]      alu_r;
    logic [AW-1:0]          wb_addr;

    ism_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ism_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (alu_a),
        .den   (alu_b),
        .done  (div_done),
        .quot  (div_quot)
    );

    // a is the cached top, b the entry below it as read from memory
    assign alu_a = top_reg;
    assign alu_b = ram_rdata;

    // Combinational operations on a and b
    always_comb
    begin
        case (op_reg)
            OP_ADD:  alu_r = alu_a + alu_b;
            OP_SUB:  alu_r = alu_a - alu_b;
            OP_MAX:  alu_r = ($signed(alu_a) < $signed(alu_b)) ? alu_b : alu_a;
            OP_MIN:  alu_r = ($signed(alu_a) < $signed(alu_b)) ? alu_a : alu_b;
            default: alu_r = alu_a;
        endcase
    end

    assign wb_addr = (op_reg == OP_SWAP) ? AW'(depth_reg - DW'(1)) : AW'(depth_reg - DW'(2));

    // Sequencer: decode, read the second entry, operate, write back, report
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        depth_next      = depth_reg;
        top_next        = top_reg;
        bottom_next     = bottom_reg;
        status_next     = status_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_top_next    = out_top_reg;
        out_bottom_next = out_bottom_reg;
        out_depth_next  = out_depth_reg;
        out_status_next = out_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = AW'(depth_reg);
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = AW'(depth_reg - DW'(2));
        div_start       = 1'b0;

        // Drop the result once taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = opcode_t'(req.req_type);
                    val_next   = req.push_value;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                status_next = ST_OK;
                state_next  = S_RESP;
                case (op_reg)
                    OP_CONST, OP_DUP:
                    begin
                        if (op_reg == OP_DUP && depth_reg == '0)
                        begin
                            status_next = ST_UNDER;
                        end
                        else if (depth_reg == DW'(STACK_DEPTH))
                        begin
                            status_next = ST_OVER;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(depth_reg);
                            ram_wdata = (op_reg == OP_CONST) ? val_reg : top_reg;
                            top_next  = ram_wdata;
                            if (depth_reg == '0)
                            begin
                                bottom_next = ram_wdata;
                            end
                            depth_next = depth_reg + DW'(1);
                        end
                    end
                    OP_NEG:
                    begin
                        if (depth_reg == '0)
                        begin
                            status_next = ST_UNDER;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(depth_reg - DW'(1));
                            ram_wdata = '0 - top_reg;
                            top_next  = ram_wdata;
                            if (depth_reg == DW'(1))
                            begin
                                bottom_next = ram_wdata;
                            end
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MAX, OP_MIN, OP_SWAP:
                    begin
                        if (depth_reg < DW'(2))
                        begin
                            status_next = ST_UNDER;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_READ:
            begin
                state_next = S_RESP;
                case (op_reg)
                    OP_ADD, OP_SUB, OP_MAX, OP_MIN:
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(depth_reg - DW'(2));
                        ram_wdata = alu_r;
                        top_next  = alu_r;
                        if (depth_reg == DW'(2))
                        begin
                            bottom_next = alu_r;
                        end
                        depth_next = depth_reg - DW'(1);
                    end
                    OP_MUL:
                    begin
                        res_next   = alu_a * alu_b;
                        state_next = S_WB;
                    end
                    OP_DIV:
                    begin
                        if (alu_b == '0)
                        begin
                            status_next = ST_DIVZ;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    OP_SWAP:
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(depth_reg - DW'(2));
                        ram_wdata = alu_a;
                        if (depth_reg == DW'(2))
                        begin
                            bottom_next = alu_a;
                        end
                        res_next   = alu_b;
                        state_next = S_WB;
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_quot;
                    state_next = S_WB;
                end
            end

            S_WB:
            begin
                ram_we    = 1'b1;
                ram_waddr = wb_addr;
                ram_wdata = res_reg;
                top_next  = res_reg;
                if (wb_addr == '0)
                begin
                    bottom_next = res_reg;
                end
                if (op_reg != OP_SWAP)
                begin
                    depth_next = depth_reg - DW'(1);
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_top_next    = (depth_reg == '0) ? '0 : top_reg;
                    out_bottom_next = (depth_reg == '0) ? '0 : bottom_reg;
                    out_depth_next  = depth_reg;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_CONST;
            val_reg        <= '0;
            depth_reg      <= '0;
            top_reg        <= '0;
            bottom_reg     <= '0;
            status_reg     <= ST_OK;
            res_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_top_reg    <= '0;
            out_bottom_reg <= '0;
            out_depth_reg  <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            val_reg        <= val_next;
            depth_reg      <= depth_next;
            top_reg        <= top_next;
            bottom_reg     <= bottom_next;
            status_reg     <= status_next;
            res_reg        <= res_next;
            out_valid_reg  <= out_valid_next;
            out_top_reg    <= out_top_next;
            out_bottom_reg <= out_bottom_next;
            out_depth_reg  <= out_depth_next;
            out_status_reg <= out_status_next;
        end
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.top_value       = out_top_reg;
    assign rsp.bottom_value    = out_bottom_reg;
    assign rsp.stack_depth_out = DEPTH_OUT_W'(out_depth_reg);
    assign rsp.status          = out_status_reg;

    // Depth never passes the stack size
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    // An accepted instruction goes straight to decode
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == S_DECODE))
        else $error("accepted instruction not decoded");

    // Overflow is reported only on a full stack
    a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && status_reg == ST_OVER) |-> (depth_reg == DW'(STACK_DEPTH)))
        else $error("overflow reported below capacity");

    // The divider completes only while the sequencer waits for it
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide wait");

endmodule

// ===== design/ism_ram.sv =====
module ism_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/ism_div.sv =====
module ism_div import ism_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] num,
    input  logic [DATA_W-1:0] den,
    output logic              done,
    output logic [DATA_W-1:0] quot
);

    localparam int unsigned CNT_W = $clog2(DATA_W + 1);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic              neg_reg,   neg_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [DATA_W-1:0] rem_reg,   rem_next;
    logic [DATA_W-1:0] quo_reg,   quo_next;
    logic [DATA_W-1:0] den_reg,   den_next;
    logic [DATA_W:0]   rem_shift;

    // One quotient bit per cycle, restoring division on magnitudes
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_shift = {rem_reg, quo_reg[DATA_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_W);
            rem_next  = '0;
            quo_next  = num[DATA_W-1] ? ('0 - num) : num;
            den_next  = den[DATA_W-1] ? ('0 - den) : den;
            neg_next  = num[DATA_W-1] ^ den[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_next = DATA_W'(rem_shift - {1'b0, den_reg});
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            neg_reg  <= neg_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            den_reg  <= den_next;
        end
    end

    // Restore the sign of the quotient
    assign done = done_reg;
    assign quot = neg_reg ? ('0 - quo_reg) : quo_reg;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import ism_pkg::*;

    localparam int unsigned CAPACITY     = STACK_DEPTH_DEF;
    localparam int          OPCODE_SPAN  = 1 << OP_W;
    localparam int          PHASE_LEN    = 64;
    localparam int          IDLE_HEAVY   = 86;
    localparam int          IDLE_LIGHT   = 23;
    localparam int          LOW_TARGET   = 6;
    localparam int          N_LOW        = 30;
    localparam int          N_TOP        = 40;
    localparam int          DRAIN_CYCLES = 64;
    localparam int          RUN_LIMIT_NS = 5_000_000;

    localparam logic [OP_W-1:0]          OP_UNUSED_HI = OP_W'(OPCODE_SPAN - 1);
    localparam logic signed [DATA_W-1:0] WORD_MIN     = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] WORD_MAX     = ~WORD_MIN;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] bottom_value;
        logic [DEPTH_OUT_W-1:0]   stack_depth_out;
        status_t                  status;
    } stack_view_t;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        logic                     pinned;
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] bottom_value;
        logic [DEPTH_OUT_W-1:0]   stack_depth_out;
        status_t                  status;
    } directed_row_t;

    typedef enum int {PH_FLOW, PH_SENDER_IDLE, PH_RECEIVER_STALL, PH_BOTH} idle_phase_t;
    typedef enum int {STAGE_LOW, STAGE_CLIMB, STAGE_TOP, STAGE_DONE} stage_t;

    localparam int DIRECTED_COUNT = 25;

    // Pinned rows carry their expected view; the rest are left to the predictor
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{OP_ADD,       32'sd0,   1'b1, 32'sd0,   32'sd0,   11'd0, ST_UNDER},
        '{OP_NEG,       32'sd0,   1'b1, 32'sd0,   32'sd0,   11'd0, ST_UNDER},
        '{OP_DUP,       32'sd0,   1'b1, 32'sd0,   32'sd0,   11'd0, ST_UNDER},
        '{OP_SWAP,      32'sd0,   1'b1, 32'sd0,   32'sd0,   11'd0, ST_UNDER},
        '{OP_UNUSED_HI, WORD_MAX, 1'b1, 32'sd0,   32'sd0,   11'd0, ST_OK},
        '{OP_CONST,     WORD_MAX, 1'b1, WORD_MAX, WORD_MAX, 11'd1, ST_OK},
        '{OP_SWAP,      32'sd0,   1'b1, WORD_MAX, WORD_MAX, 11'd1, ST_UNDER},
        '{OP_DIV,       32'sd0,   1'b1, WORD_MAX, WORD_MAX, 11'd1, ST_UNDER},
        '{OP_CONST,     WORD_MIN, 1'b1, WORD_MIN, WORD_MAX, 11'd2, ST_OK},
        '{OP_ADD,       32'sd0,   1'b1, -32'sd1,  -32'sd1,  11'd1, ST_OK},
        '{OP_CONST,     WORD_MIN, 1'b0, 32'sd0,   32'sd0,   11'd0, ST_OK},
        '{OP_DIV,       32'sd0,   1'b1, WORD_MIN, WORD_MIN, 11'd1, ST_OK},
        '{OP_NEG,       32'sd0,   1'b1, WORD_MIN, WORD_MIN, 11'd1, ST_OK},
        '{OP_CONST,     32'sd0,   1'b0, 32'sd0,   32'sd0,   11'd0, ST_OK},
        '{OP_SWAP,      32'sd0,   1'b0, 32'sd0,   32'sd0,   11'd0, ST_OK},
        '{OP_DIV,       32'sd0,   1'b1, WORD_MIN, 32'sd0,   11'd2, ST_DIVZ},
        '{OP_DUP,       32'sd0,   1'b0, 32'sd0,   32'sd0,   11'd0, ST_OK},
        '{OP_MUL,       32'sd0,   1'b0, 32'sd0,   32'sd0,   11'd0, ST_OK},
        '{OP_CONST,     32'sd2,   1'b0, 32'sd0,   32'sd0,   11'd0, ST_OK},
        '{OP_CONST,     -32'sd7,  1'b0, 32'sd0,   32'sd0,   11'd0, ST_OK},
        '{OP_DIV,       32'sd0,   1'b0, 32'sd0,   32'sd0,   11'd0, ST_OK},
        '{OP_SUB,       32'sd0,   1'b0, 32'sd0,   32'sd0,   11'd0, ST_OK},
        '{OP_CONST,     32'sd5,   1'b0, 32'sd0,   32'sd0,   11'd0, ST_OK},
        '{OP_MAX,       32'sd0,   1'b0, 32'sd0,   32'sd0,   11'd0, ST_OK},
        '{OP_MIN,       32'sd0,   1'b0, 32'sd0,   32'sd0,   11'd0, ST_OK}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ism_req_if req_ch ();
    ism_rsp_if rsp_ch ();

    integer_stack_machine #(
        .STACK_DEPTH (CAPACITY)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the stack, advanced once per accepted instruction
    logic [DATA_W-1:0] shadow_stack [CAPACITY];
    int                shadow_depth = 0;

    stack_view_t expected_views [$];
    idle_phase_t idle_phase     = PH_FLOW;
    bit          draining       = 1'b0;
    int          failures       = 0;
    int          instr_count    = 0;
    int          result_count   = 0;
    int          deepest        = 0;
    int          status_seen [4] = '{0, 0, 0, 0};

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // Execute one instruction on the shadow stack and return the view after it
    function automatic stack_view_t execute_instr(input logic [OP_W-1:0] op,
                                                  input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] r;
        logic [DATA_W-1:0] mag_a;
        logic [DATA_W-1:0] mag_b;
        logic [DATA_W-1:0] quo;
        status_t           st;
        stack_view_t       view;
        st = ST_OK;
        a  = '0;
        b  = '0;
        r  = '0;
        if (shadow_depth >= 1)
            a = shadow_stack[shadow_depth - 1];
        if (shadow_depth >= 2)
            b = shadow_stack[shadow_depth - 2];
        case (op)
            OP_CONST, OP_DUP:
            begin
                if (op == OP_DUP && shadow_depth < 1)
                    st = ST_UNDER;
                else if (shadow_depth >= CAPACITY)
                    st = ST_OVER;
                else
                begin
                    shadow_stack[shadow_depth] = (op == OP_CONST) ? val : a;
                    shadow_depth++;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MAX, OP_MIN:
            begin
                if (shadow_depth < 2)
                    st = ST_UNDER;
                else
                begin
                    case (op)
                        OP_ADD: r = a + b;
                        OP_SUB: r = a - b;
                        OP_MUL: r = a * b;
                        OP_DIV:
                        begin
                            // Divide magnitudes, then restore the sign; truncates toward zero
                            if (b == '0)
                                st = ST_DIVZ;
                            else
                            begin
                                mag_a = a[DATA_W-1] ? -a : a;
                                mag_b = b[DATA_W-1] ? -b : b;
                                quo   = mag_a / mag_b;
                                r     = (a[DATA_W-1] ^ b[DATA_W-1]) ? -quo : quo;
                            end
                        end
                        OP_MAX:  r = ($signed(a) < $signed(b)) ? b : a;
                        default: r = ($signed(a) < $signed(b)) ? a : b;
                    endcase
                    if (st == ST_OK)
                    begin
                        shadow_stack[shadow_depth - 2] = r;
                        shadow_depth--;
                    end
                end
            end
            OP_NEG:
            begin
                if (shadow_depth < 1)
                    st = ST_UNDER;
                else
                    shadow_stack[shadow_depth - 1] = -a;
            end
            OP_SWAP:
            begin
                if (shadow_depth < 2)
                    st = ST_UNDER;
                else
                begin
                    shadow_stack[shadow_depth - 1] = b;
                    shadow_stack[shadow_depth - 2] = a;
                end
            end
            default: ;
        endcase
        view.top_value       = (shadow_depth > 0) ? shadow_stack[shadow_depth - 1] : '0;
        view.bottom_value    = (shadow_depth > 0) ? shadow_stack[0] : '0;
        view.stack_depth_out = DEPTH_OUT_W'(shadow_depth);
        view.status          = st;
        return view;
    endfunction

    // Offer one instruction beat, hold it until accepted, then log its expected view
    task automatic send_instr(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val,
                              input bit pinned, input stack_view_t pinned_view);
        stack_view_t predicted;
        int          idle_pct;
        idle_pct = (idle_phase == PH_SENDER_IDLE) ? IDLE_HEAVY :
                   (idle_phase == PH_BOTH) ? IDLE_LIGHT : 0;
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= op;
        req_ch.push_value <= val;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predicted = execute_instr(op, val);
        expected_views.push_back(pinned ? pinned_view : predicted);
        instr_count++;
        if (shadow_depth > deepest)
            deepest = shadow_depth;
        idle_phase = idle_phase_t'((instr_count / PHASE_LEN) % 4);
    endtask

    // Drive the instruction stream: directed rows, then three random stages
    initial
    begin
        stack_view_t              pin_view;
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] val;
        stage_t                   stage;
        int                       stage_items;
        int                       roll;
        int                       target;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= '0;
        req_ch.push_value <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            pin_view = '{DIRECTED_ROWS[i].top_value, DIRECTED_ROWS[i].bottom_value,
                         DIRECTED_ROWS[i].stack_depth_out, DIRECTED_ROWS[i].status};
            send_instr(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].value,
                       DIRECTED_ROWS[i].pinned, pin_view);
        end

        // Mix near the bottom, climb to a full stack, then mix against the ceiling
        stage       = STAGE_LOW;
        stage_items = 0;
        while (stage != STAGE_DONE)
        begin
            roll = $urandom_range(99);
            case ($urandom_range(9))
                0:       val = $urandom_range(1) ? WORD_MIN : WORD_MAX;
                1:       val = int'($urandom_range(2)) - 1;
                2, 3, 4: val = int'($urandom_range(16)) - 8;
                default: val = $urandom;
            endcase
            if (stage == STAGE_CLIMB)
            begin
                if (roll < 2)
                    op = OP_NEG;
                else if (roll < 4)
                    op = OP_SWAP;
                else if (roll < 5)
                    op = OP_W'($urandom_range(OPCODE_SPAN - 1, OP_SWAP + 1));
                else if (roll < 88)
                    op = OP_CONST;
                else
                    op = OP_DUP;
            end
            else
            begin
                target = (stage == STAGE_LOW) ? LOW_TARGET : CAPACITY + 1;
                if (roll < 8)
                    op = OP_W'($urandom_range(OPCODE_SPAN - 1));
                else if (shadow_depth < 2 || (shadow_depth < target && roll < 54))
                    op = ($urandom_range(3) == 0) ? OP_DUP : OP_CONST;
                else
                    op = OP_W'($urandom_range(OP_SWAP, OP_ADD));
            end
            send_instr(op, val, 1'b0, '0);

            // Advance the stage
            stage_items++;
            if (stage == STAGE_LOW && stage_items == N_LOW)
                stage = STAGE_CLIMB;
            else if (stage == STAGE_CLIMB && shadow_depth == CAPACITY)
            begin
                stage       = STAGE_TOP;
                stage_items = 0;
            end
            else if (stage == STAGE_TOP && stage_items == N_TOP)
                stage = STAGE_DONE;
        end

        // Drop valid, open the receiver and let the last results drain
        req_ch.valid <= 1'b0;
        draining = 1'b1;
        while (expected_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d instructions, %0d results checked, deepest stack %0d of %0d.",
                 instr_count, result_count, deepest, CAPACITY);
        $display("Statuses: ok %0d, underflow %0d, overflow %0d, divide by zero %0d.",
                 status_seen[ST_OK], status_seen[ST_UNDER], status_seen[ST_OVER],
                 status_seen[ST_DIVZ]);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Check each result beat against the oldest expectation, then pick the next ready
    always @(posedge clk)
    begin
        stack_view_t exp_view;
        int          stall_pct;
        if (rst_n)
        begin
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (expected_views.size() == 0)
                begin
                    $error("result beat with no instruction outstanding");
                    failures++;
                end
                else
                begin
                    exp_view = expected_views.pop_front();
                    result_count++;
                    status_seen[exp_view.status]++;
                    if (rsp_ch.top_value !== exp_view.top_value)
                    begin
                        $error("top_value: expected %0d, actual %0d",
                               exp_view.top_value, rsp_ch.top_value);
                        failures++;
                    end
                    if (rsp_ch.bottom_value !== exp_view.bottom_value)
                    begin
                        $error("bottom_value: expected %0d, actual %0d",
                               exp_view.bottom_value, rsp_ch.bottom_value);
                        failures++;
                    end
                    if (rsp_ch.stack_depth_out !== exp_view.stack_depth_out)
                    begin
                        $error("stack_depth_out: expected %0d, actual %0d",
                               exp_view.stack_depth_out, rsp_ch.stack_depth_out);
                        failures++;
                    end
                    if (rsp_ch.status !== exp_view.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               exp_view.status, rsp_ch.status);
                        failures++;
                    end
                end
            end
            stall_pct = draining ? 0 :
                        (idle_phase == PH_RECEIVER_STALL) ? IDLE_HEAVY :
                        (idle_phase == PH_BOTH) ? IDLE_LIGHT : 0;
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
        else
        begin
            // Hold the receiver closed through reset
            rsp_ch.ready <= 1'b0;
        end
    end

endmodule

// ===== filelist.f =====
design/ism_pkg.sv
design/ism_req_if.sv
design/ism_rsp_if.sv
design/ism_ram.sv
design/ism_div.sv
design/integer_stack_machine.sv
tb/sv/tb.sv
